### rtl/cmf_pkg.sv
// cmf_pkg: beat types, entry constants and controller states for the
// can rx mask filter table; no dependencies
package cmf_pkg;

  localparam logic [15:0] ID_BITS  = 16'h07FF;
  localparam logic [15:0] RTR_BIT  = 16'h8000;
  localparam logic [15:0] ALL_ONES = 16'hFFFF;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_MATCH = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_ILLEGAL = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [3:0]  entry_index;
    logic [10:0] entry_ident;
    logic [10:0] entry_mask;
    logic        entry_rtr;
    logic        has_consumer;
    logic [28:0] frame_id;
    logic        frame_remote;
  } cmd_t;

  typedef struct packed {
    logic       status;
    logic       hit;
    logic       deliver;
    logic [3:0] match_index;
  } res_t;

  // entry write toward the table
  typedef struct packed {
    logic        en;
    logic [3:0]  index;
    logic [10:0] ident;
    logic [10:0] mask;
    logic        rtr;
  } wr_t;

  // stored entry as seen by the compare
  typedef struct packed {
    logic [15:0] key;
    logic [15:0] mask;
    logic        consumer;
  } ent_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

endpackage

### rtl/cmf_ram.sv
// cmf_ram: generic simple dual port ram, one write and one registered read
// no dependencies
module cmf_ram #(
  parameter int WIDTH = 23,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/cmf_table.sv
// cmf_table: filter entry store, ram for key and mask plus consumer flops
// depends on cmf_pkg and cmf_ram
module cmf_table #(
  parameter int NUM_ENTRIES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmf_pkg::wr_t         wr,
  input  logic                 rd_en,
  input  logic [(NUM_ENTRIES > 1 ? $clog2(NUM_ENTRIES) : 1)-1:0] rd_addr,
  output cmf_pkg::ent_t        rd_ent
);

  localparam int AW = NUM_ENTRIES > 1 ? $clog2(NUM_ENTRIES) : 1;
  localparam int DW = 23;

  logic [NUM_ENTRIES-1:0] consumer;
  logic [AW-1:0]          waddr;
  logic [DW-1:0]          wdata;
  logic [DW-1:0]          rdata;
  logic [AW-1:0]          rd_idx;

  assign waddr = AW'(wr.index);
  assign wdata = {wr.rtr, wr.ident, wr.mask};

  cmf_ram #(
    .WIDTH(DW),
    .DEPTH(NUM_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (wr.en),
    .waddr(waddr),
    .wdata(wdata),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  // consumer mark doubles as written flag
  always_ff @(posedge clk) begin
    if (rst) begin
      consumer <= '0;
    end else if (wr.en) begin
      consumer[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_idx <= rd_addr;
    end
  end

  // unwritten entries read as key 0, mask all ones
  always_comb begin
    rd_ent.consumer = consumer[rd_idx];
    if (consumer[rd_idx]) begin
      rd_ent.key  = {rdata[22], 4'b0000, rdata[21:11]};
      rd_ent.mask = cmf_pkg::RTR_BIT | {5'b00000, rdata[10:0]};
    end else begin
      rd_ent.key  = '0;
      rd_ent.mask = cmf_pkg::ALL_ONES;
    end
  end

endmodule

### rtl/cmf_ctrl.sv
// cmf_ctrl: command sequencer, entry write check and pipelined table scan
// depends on cmf_pkg
module cmf_ctrl #(
  parameter int NUM_ENTRIES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  cmf_pkg::cmd_t                       cmd,
  input  logic [$clog2(NUM_ENTRIES+1)-1:0]    limit,
  output cmf_pkg::wr_t                        wr,
  output logic                                rd_en,
  output logic [(NUM_ENTRIES > 1 ? $clog2(NUM_ENTRIES) : 1)-1:0] rd_addr,
  input  cmf_pkg::ent_t                       rd_ent,
  output logic                                done_valid,
  input  logic                                done_ready,
  output cmf_pkg::res_t                       done
);

  localparam int AW = NUM_ENTRIES > 1 ? $clog2(NUM_ENTRIES) : 1;
  localparam int CW = $clog2(NUM_ENTRIES + 1);

  cmf_pkg::state_t state, state_next;
  logic [15:0]     fkey, fkey_next;
  logic [CW-1:0]   iss, iss_next;
  logic            pend, pend_next;
  logic [AW-1:0]   cidx, cidx_next;
  cmf_pkg::res_t   res, res_next;
  logic            wr_ok;
  logic            match;

  assign wr_ok  = cmd.has_consumer && (int'(cmd.entry_index) < int'(limit));
  assign match  = ((fkey ^ rd_ent.key) & rd_ent.mask) == 16'h0000;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cmf_pkg::ST_IDLE;
      pend  <= 1'b0;
      iss   <= '0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      iss   <= iss_next;
    end
  end

  always_ff @(posedge clk) begin
    fkey <= fkey_next;
    cidx <= cidx_next;
    res  <= res_next;
  end

  always_comb begin
    state_next = state;
    fkey_next  = fkey;
    iss_next   = iss;
    pend_next  = 1'b0;
    cidx_next  = cidx;
    res_next   = res;
    cmd_ready  = 1'b0;
    done_valid = 1'b0;
    done       = res;
    rd_en      = 1'b0;
    rd_addr    = AW'(iss);
    wr.en      = 1'b0;
    wr.index   = cmd.entry_index;
    wr.ident   = cmd.entry_ident;
    wr.mask    = cmd.entry_mask;
    wr.rtr     = cmd.entry_rtr;

    case (state)
      cmf_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          res_next = '0;
          iss_next = '0;
          fkey_next = cmd.frame_id[15:0] | (cmd.frame_remote ? cmf_pkg::RTR_BIT : 16'h0000);
          if (cmd.mode == cmf_pkg::MODE_WRITE) begin
            wr.en = wr_ok;
            res_next.status = wr_ok ? cmf_pkg::STATUS_OK : cmf_pkg::STATUS_ILLEGAL;
            state_next = cmf_pkg::ST_HOLD;
          end else if (limit == '0) begin
            state_next = cmf_pkg::ST_HOLD;
          end else begin
            state_next = cmf_pkg::ST_SCAN;
          end
        end
      end

      cmf_pkg::ST_SCAN: begin
        if (pend && match) begin
          res_next.hit         = 1'b1;
          res_next.deliver     = rd_ent.consumer;
          res_next.match_index = 4'(cidx);
          state_next           = cmf_pkg::ST_HOLD;
        end else if (!pend && iss == limit) begin
          state_next = cmf_pkg::ST_HOLD;
        end else if (iss < limit) begin
          rd_en     = 1'b1;
          pend_next = 1'b1;
          cidx_next = AW'(iss);
          iss_next  = iss + CW'(1);
        end
      end

      cmf_pkg::ST_HOLD: begin
        done_valid = 1'b1;
        if (done_ready) begin
          state_next = cmf_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = cmf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/can_rx_mask_filter_table.sv
// can_rx_mask_filter_table: top level, config register, table and output stage
// depends on cmf_pkg, cmf_ctrl, cmf_table
//
//   channel   signals                        payload
//   command   cmd_valid / cmd_ready          cmd  (cmf_pkg::cmd_t)
//   result    res_valid / res_ready          res  (cmf_pkg::res_t)
//   config    cfg_we                         cfg_wdata (entries_in_use)
//
// an entry write, or a match with limit 0, goes from accept straight to ST_HOLD and then into the result register
// a match scans one entry a cycle through the ram read port and stops at the first hit
// or after limit entries, limit being entries_in_use capped at NUM_ENTRIES
// reset clears the consumer flags and the control state
// the output register lets the next command in while a result waits
module can_rx_mask_filter_table #(
  parameter int NUM_ENTRIES = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  cmf_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output cmf_pkg::res_t res,
  input  logic          cfg_we,
  input  logic [4:0]    cfg_wdata
);

  localparam int AW = NUM_ENTRIES > 1 ? $clog2(NUM_ENTRIES) : 1;
  localparam int CW = $clog2(NUM_ENTRIES + 1);

  logic [4:0]    entries_in_use;
  logic [CW-1:0] limit;
  cmf_pkg::wr_t  wr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  cmf_pkg::ent_t rd_ent;
  logic          done_valid;
  logic          done_ready;
  cmf_pkg::res_t done;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= 5'd16;
    end else if (cfg_we) begin
      entries_in_use <= cfg_wdata;
    end
  end

  assign limit = (int'(entries_in_use) > NUM_ENTRIES) ? CW'(NUM_ENTRIES)
                                                      : CW'(entries_in_use);

  cmf_ctrl #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .limit     (limit),
    .wr        (wr),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_ent    (rd_ent),
    .done_valid(done_valid),
    .done_ready(done_ready),
    .done      (done)
  );

  cmf_table #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_ent (rd_ent)
  );

  // result beat register
  assign done_ready = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (done_ready) begin
      res_valid <= done_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (done_ready && done_valid) begin
      res <= done;
    end
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for can_rx_mask_filter_table, entry writes and frame
// lookups with random idle on both channels, checked against a local filter table
// depends on cmf_pkg and the can_rx_mask_filter_table rtl
module tb_top;

  localparam int N_ENT = 16;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmf_pkg::cmd_t cmd = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  cmf_pkg::res_t res;
  logic cfg_we = 1'b0;
  logic [4:0] cfg_wdata = '0;

  can_rx_mask_filter_table #(
    .NUM_ENTRIES(N_ENT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // local copy of the filter table
  logic [15:0] tbl_key [N_ENT];
  logic [15:0] tbl_mask [N_ENT];
  logic tbl_owned [N_ENT];
  logic [4:0] tbl_limit = 5'd16;

  // entries as the stimulus intends them, used only to aim frames
  logic [15:0] aim_key [N_ENT];
  logic [15:0] aim_mask [N_ENT];

  cmf_pkg::cmd_t pending_cmds [$];
  cmf_pkg::res_t verdict_q [$];
  int n_pushed = 0;
  int n_results = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int take_hold = 0;
  logic calm = 1'b0;
  cmf_pkg::res_t want_res;

  function automatic int live_entries();
    return (tbl_limit > N_ENT) ? N_ENT : int'(tbl_limit);
  endfunction

  function automatic int idle_draw();
    return calm ? 0 : int'($urandom_range(0, 12));
  endfunction

  // applies one beat to the table and returns the verdict it gives
  function automatic cmf_pkg::res_t filter_verdict(cmf_pkg::cmd_t c);
    cmf_pkg::res_t r;
    logic [15:0] fkey;
    int lim;
    r = '0;
    lim = live_entries();
    if (c.mode == cmf_pkg::MODE_WRITE) begin
      if (c.has_consumer && c.entry_index < lim) begin
        tbl_key[c.entry_index] = ({5'b0, c.entry_ident} & cmf_pkg::ID_BITS) |
                                 (c.entry_rtr ? cmf_pkg::RTR_BIT : 16'h0);
        tbl_mask[c.entry_index] = ({5'b0, c.entry_mask} & cmf_pkg::ID_BITS) |
                                  cmf_pkg::RTR_BIT;
        tbl_owned[c.entry_index] = 1'b1;
        r.status = cmf_pkg::STATUS_OK;
      end else begin
        r.status = cmf_pkg::STATUS_ILLEGAL;
      end
    end else begin
      r.status = cmf_pkg::STATUS_OK;
      fkey = c.frame_id[15:0] | (c.frame_remote ? cmf_pkg::RTR_BIT : 16'h0);
      for (int i = 0; i < lim; i++) begin
        if (!r.hit && ((fkey ^ tbl_key[i]) & tbl_mask[i]) == 16'h0) begin
          r.hit = 1'b1;
          r.deliver = tbl_owned[i];
          r.match_index = i[3:0];
        end
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 40)
      $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  task automatic queue_write(input logic [3:0] idx, input logic [10:0] ident,
                             input logic [10:0] msk, input logic rtr, input logic cons);
    cmf_pkg::cmd_t c;
    c.mode = cmf_pkg::MODE_WRITE;
    c.entry_index = idx;
    c.entry_ident = ident;
    c.entry_mask = msk;
    c.entry_rtr = rtr;
    c.has_consumer = cons;
    c.frame_id = 29'($urandom);
    c.frame_remote = 1'($urandom);
    if (cons && idx < live_entries()) begin
      aim_key[idx] = {rtr, 4'b0, ident};
      aim_mask[idx] = {1'b1, 4'b0, msk};
    end
    pending_cmds.push_back(c);
    n_pushed++;
  endtask

  task automatic queue_frame(input logic [28:0] fid, input logic remote);
    cmf_pkg::cmd_t c;
    c.mode = cmf_pkg::MODE_MATCH;
    c.entry_index = 4'($urandom);
    c.entry_ident = 11'($urandom);
    c.entry_mask = 11'($urandom);
    c.entry_rtr = 1'($urandom);
    c.has_consumer = 1'($urandom);
    c.frame_id = fid;
    c.frame_remote = remote;
    pending_cmds.push_back(c);
    n_pushed++;
  endtask

  // frame built to pass a chosen entry in use
  task automatic queue_aimed_frame();
    int j;
    logic [15:0] k;
    logic [15:0] m;
    logic [28:0] fid;
    logic rem;
    j = $urandom_range(0, live_entries() - 1);
    k = aim_key[j];
    m = aim_mask[j];
    fid = 29'($urandom);
    fid[14:0] = (k[14:0] & m[14:0]) | (fid[14:0] & ~m[14:0]);
    rem = 1'($urandom);
    if (k[15]) begin
      if (!rem)
        fid[15] = 1'b1;
    end else begin
      fid[15] = 1'b0;
      rem = 1'b0;
    end
    queue_frame(fid, rem);
  endtask

  task automatic queue_noise();
    logic [63:0] r;
    cmf_pkg::cmd_t c;
    r = {$urandom, $urandom};
    c = r[58:0];
    if (c.mode == cmf_pkg::MODE_WRITE)
      queue_write(c.entry_index, c.entry_ident, c.entry_mask, c.entry_rtr, c.has_consumer);
    else
      queue_frame(c.frame_id, c.frame_remote);
  endtask

  task automatic set_entries_in_use(input logic [4:0] v);
    while (n_results != n_pushed)
      @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    tbl_limit = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (cmd_valid && cmd_ready)
        verdict_q.push_back(filter_verdict(cmd));
      if (!cmd_valid || cmd_ready) begin
        if (send_gap != 0 || pending_cmds.size() == 0) begin
          cmd_valid <= 1'b0;
          if (send_gap != 0)
            send_gap <= send_gap - 1;
        end else begin
          cmd <= pending_cmds.pop_front();
          cmd_valid <= 1'b1;
          send_gap <= idle_draw();
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
      take_hold <= 0;
    end else begin
      if (res_valid && res_ready) begin
        n_results++;
        if (verdict_q.size() == 0) begin
          flag_mismatch("unexpected beat", int'(res), 0);
        end else begin
          want_res = verdict_q.pop_front();
          if (res.status !== want_res.status)
            flag_mismatch("status", int'(res.status), int'(want_res.status));
          if (res.hit !== want_res.hit)
            flag_mismatch("hit", int'(res.hit), int'(want_res.hit));
          if (res.deliver !== want_res.deliver)
            flag_mismatch("deliver", int'(res.deliver), int'(want_res.deliver));
          if (res.match_index !== want_res.match_index)
            flag_mismatch("match_index", int'(res.match_index),
                          int'(want_res.match_index));
        end
        take_hold = idle_draw();
        res_ready <= (take_hold == 0);
      end else if (take_hold > 0) begin
        take_hold = take_hold - 1;
        res_ready <= (take_hold == 0);
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int phase_limits [10];
    int pick;
    phase_limits = '{16, 5, 17, 0, 1, 8, 31, 12, 2, 16};
    for (int i = 0; i < N_ENT; i++) begin
      tbl_key[i] = 16'h0;
      tbl_mask[i] = cmf_pkg::ALL_ONES;
      tbl_owned[i] = 1'b0;
      aim_key[i] = 16'h0;
      aim_mask[i] = cmf_pkg::ALL_ONES;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // untouched table after reset
    queue_frame(29'h0, 1'b0);
    queue_frame(29'h1FFFFFFF, 1'b1);
    queue_frame(29'h0FFF0000, 1'b0);
    queue_write(4'd0, 11'h7FF, 11'h7FF, 1'b1, 1'b1);
    queue_write(4'd15, 11'h000, 11'h000, 1'b0, 1'b1);
    queue_write(4'd3, 11'h555, 11'h7FF, 1'b0, 1'b0);
    queue_frame(29'h000007FF, 1'b1);
    // identifier bit 15 stands in for the rtr flag
    queue_frame(29'h000087FF, 1'b0);
    queue_frame(29'h000007FF, 1'b0);
    queue_frame(29'h00000123, 1'b1);
    // first hit on a reset entry without consumer ends the search
    queue_frame(29'h00010000, 1'b0);

    set_entries_in_use(5'd0);
    queue_frame(29'h0, 1'b0);
    queue_write(4'd0, 11'h123, 11'h7FF, 1'b0, 1'b1);

    // above the table size acts as full size, entries kept
    set_entries_in_use(5'd31);
    queue_frame(29'h000007FF, 1'b0);
    queue_write(4'd15, 11'h2AA, 11'h555, 1'b1, 1'b1);

    set_entries_in_use(5'd1);
    queue_frame(29'h000007FF, 1'b0);
    queue_write(4'd1, 11'h001, 11'h7FF, 1'b0, 1'b1);
    queue_write(4'd0, 11'h400, 11'h7F0, 1'b0, 1'b1);
    queue_frame(29'h0000040F, 1'b0);

    foreach (phase_limits[p]) begin
      set_entries_in_use(5'(phase_limits[p]));
      calm = (p % 3 == 1);
      repeat (55) begin
        pick = $urandom_range(0, 9);
        if (live_entries() == 0 || pick >= 8)
          queue_noise();
        else if (pick < 3)
          queue_write(4'($urandom_range(0, live_entries() - 1)), 11'($urandom),
                      11'($urandom), 1'($urandom), 1'b1);
        else
          queue_aimed_frame();
      end
    end

    while (n_results < n_pushed)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (verdict_q.size() != 0)
      flag_mismatch("missing beats", 0, verdict_q.size());
    if (mismatch_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
